>>> sv/gss_pkg.sv
// Shared types and constants of the Gray-Scott stencil stream.
`timescale 1ns / 1ps
package gss_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIFFUSION_A = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIFFUSION_B = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FEED_RATE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KILL_RATE   = 3'd5;

    localparam logic [15:0] ONE_Q15     = 16'd32768;
    localparam int          Q_LIM       = 524288;
    localparam int          Q_BIAS      = 2621440;
    localparam logic [22:0] RECIP5      = 23'd6710887;
    localparam int          RECIP_SHIFT = 25;

    typedef struct packed {
        logic [15:0] in_a;
        logic [15:0] in_b;
    } t_in_word;

    typedef struct packed {
        logic [15:0] out_a;
        logic [15:0] out_b;
        logic [7:0]  grey_level;
        logic [7:0]  cell_col;
        logic [9:0]  cell_row;
        logic        last_of_run;
    } t_out_word;

    typedef struct packed {
        logic [15:0] diff_a;
        logic [15:0] diff_b;
        logic [15:0] feed;
        logic [15:0] kill;
    } t_rates;

endpackage

>>> sv/gray_scott_stencil_stream.sv
// Top level: line buffers, 3x3 window, result slots and output register.
//
//  channel | direction | handshake                 | word
//  --------+-----------+---------------------------+-----------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_in_word  (A, B)
//  out     | output    | o_out_valid / i_out_ready | o_out_word (A, B, grey, pos)
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// Each cell passes through a RAM read, a load step, the update pipeline, the
// emission of each pending result slot while the output is free, and a closing
// step back to idle, where the next cell is taken.
// Reset is synchronous and active low; line buffers hold no reset value.
// A stalled output holds the result register and the slots not yet emitted.
`timescale 1ns / 1ps
module gray_scott_stencil_stream #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  gss_pkg::t_in_word                i_in_word,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output gss_pkg::t_out_word               o_out_word,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [gss_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [15:0]                      i_cfg_data
);
    import gss_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOAD = 4'b0010,
        ST_CALC = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

    t_state r_state;
    logic [8:0]  r_width;
    logic [10:0] r_height;
    t_rates      r_rates;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [31:0]   r_cur;
    logic [5:0][31:0] r_win;
    logic [2:0]    r_slot_en;
    t_out_word [2:0] r_slot;
    logic          r_interior;
    logic          r_out_valid;
    t_out_word     r_out;

    logic [31:0] w_eff, h_eff;
    logic [CW-1:0] w_last;
    logic [RW-1:0] h_last;
    logic in_acc, out_free, emit_load;
    logic [31:0] up1, up2;
    logic [2:0][31:0] col_new;
    logic [8:0][31:0] taps;
    logic calc_done;
    logic [15:0] calc_a, calc_b;
    logic [7:0]  calc_grey;
    logic [15:0] sat_a, sat_b;
    logic [1:0]  pick;
    logic [2:0]  n_slot_en;
    t_out_word   emit_word;

    always_comb begin
        if (r_width < 9'd3) begin
            w_eff = 32'd3;
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            w_eff = 32'(MAX_WIDTH);
        end else begin
            w_eff = 32'(r_width);
        end
        if (r_height < 11'd3) begin
            h_eff = 32'd3;
        end else if (32'(r_height) > 32'(MAX_HEIGHT)) begin
            h_eff = 32'(MAX_HEIGHT);
        end else begin
            h_eff = 32'(r_height);
        end
        w_last = CW'(w_eff - 32'd1);
        h_last = RW'(h_eff - 32'd1);
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign sat_a = (i_in_word.in_a > ONE_Q15) ? ONE_Q15 : i_in_word.in_a;
    assign sat_b = (i_in_word.in_b > ONE_Q15) ? ONE_Q15 : i_in_word.in_b;

    gss_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_line_one (
        .i_clk   (i_clk),
        .i_we    (r_state == ST_LOAD),
        .i_waddr (r_col),
        .i_wdata (r_cur),
        .i_re    (in_acc),
        .i_raddr (r_col),
        .o_rdata (up1)
    );

    gss_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_line_two (
        .i_clk   (i_clk),
        .i_we    (r_state == ST_LOAD),
        .i_waddr (r_col),
        .i_wdata (up1),
        .i_re    (in_acc),
        .i_raddr (r_col),
        .o_rdata (up2)
    );

    always_comb begin
        col_new[0] = up2;
        col_new[1] = up1;
        col_new[2] = r_cur;
        for (int i = 0; i < 3; i++) begin
            taps[i*3 + 0] = r_win[i];
            taps[i*3 + 1] = r_win[3 + i];
            taps[i*3 + 2] = col_new[i];
        end
    end

    gss_calc u_calc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_LOAD),
        .i_taps  (taps),
        .i_rates (r_rates),
        .o_done  (calc_done),
        .o_a     (calc_a),
        .o_b     (calc_b),
        .o_grey  (calc_grey)
    );

    always_comb begin
        pick      = 2'd0;
        n_slot_en = r_slot_en;
        priority if (r_slot_en[0]) begin
            pick         = 2'd0;
            n_slot_en[0] = 1'b0;
        end else if (r_slot_en[1]) begin
            pick         = 2'd1;
            n_slot_en[1] = 1'b0;
        end else begin
            pick         = 2'd2;
            n_slot_en[2] = 1'b0;
        end
        emit_load = (r_state == ST_EMIT) && (r_slot_en != 3'b000) && out_free;
        emit_word = r_slot[pick];
        emit_word.last_of_run = (n_slot_en == 3'b000);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_width     <= 9'd200;
            r_height    <= 11'd200;
            r_rates     <= '{diff_a: 16'd32768, diff_b: 16'd16384,
                             feed: 16'd1802, kill: 16'd2032};
            r_col       <= '0;
            r_row       <= '0;
            r_win       <= '0;
            r_slot_en   <= 3'b000;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_GRID_WIDTH: begin
                        r_width <= i_cfg_data[8:0];
                        r_col   <= '0;
                        r_row   <= '0;
                    end
                    CFG_GRID_HEIGHT: begin
                        r_height <= i_cfg_data[10:0];
                        r_col    <= '0;
                        r_row    <= '0;
                    end
                    CFG_DIFFUSION_A: r_rates.diff_a <= i_cfg_data;
                    CFG_DIFFUSION_B: r_rates.diff_b <= i_cfg_data;
                    CFG_FEED_RATE:   r_rates.feed   <= i_cfg_data;
                    CFG_KILL_RATE:   r_rates.kill   <= i_cfg_data;
                    default: ;
                endcase
            end

            if (emit_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_state <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    r_slot_en <= {r_row == h_last,
                                  (r_row != '0) && (r_col == w_last),
                                  (r_row != '0) && (r_col != '0)};
                    r_win[2:0] <= r_win[5:3];
                    r_win[5:3] <= col_new;
                    if (r_col == w_last) begin
                        r_col <= '0;
                        r_row <= (r_row == h_last) ? '0 : r_row + RW'(1);
                    end else begin
                        r_col <= r_col + CW'(1);
                    end
                    r_state <= ST_CALC;
                end
                ST_CALC: begin
                    if (calc_done) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (r_slot_en == 3'b000) begin
                        r_state <= ST_IDLE;
                    end else if (out_free) begin
                        r_slot_en <= n_slot_en;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cur <= {sat_a, sat_b};
        end
        if (r_state == ST_LOAD) begin
            r_interior <= (r_col > CW'(1)) && (r_row > RW'(1));
            r_slot[0]  <= '{out_a: r_win[4][31:16], out_b: r_win[4][15:0],
                            grey_level: 8'd0, cell_col: 8'(r_col - CW'(1)),
                            cell_row: 10'(r_row - RW'(1)), last_of_run: 1'b0};
            r_slot[1]  <= '{out_a: up1[31:16], out_b: up1[15:0], grey_level: 8'd0,
                            cell_col: 8'(r_col), cell_row: 10'(r_row - RW'(1)),
                            last_of_run: 1'b0};
            r_slot[2]  <= '{out_a: r_cur[31:16], out_b: r_cur[15:0], grey_level: 8'd0,
                            cell_col: 8'(r_col), cell_row: 10'(r_row),
                            last_of_run: 1'b0};
        end
        if ((r_state == ST_CALC) && calc_done && r_interior) begin
            r_slot[0].out_a      <= calc_a;
            r_slot[0].out_b      <= calc_b;
            r_slot[0].grey_level <= calc_grey;
        end
        if (emit_load) begin
            r_out <= emit_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

`ifndef SYNTHESIS
    a_done_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        calc_done |-> (r_state == ST_CALC))
        else $error("update pipeline finished outside the wait state");
    a_slots_empty_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> (r_slot_en == 3'b000))
        else $error("new word accepted with results still pending");
    a_emit_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_EMIT) && (r_slot_en == 3'b000)) |=> (r_state == ST_IDLE))
        else $error("emit did not return to idle");
    a_last_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_load && (n_slot_en == 3'b000)) |=> (r_slot_en == 3'b000))
        else $error("last flag set with slots remaining");
`endif
endmodule

>>> sv/gss_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module gss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> sv/gss_calc.sv
// Six-stage Laplacian and Gray-Scott update pipeline for one interior cell.
`timescale 1ns / 1ps
module gss_calc (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [8:0][31:0] i_taps,
    input  gss_pkg::t_rates i_rates,
    output logic            o_done,
    output logic [15:0]     o_a,
    output logic [15:0]     o_b,
    output logic [7:0]      o_grey
);
    import gss_pkg::*;

    function automatic logic signed [22:0] lap20(input logic [8:0][15:0] f);
        logic [17:0] e;
        logic [17:0] k;
        e = 18'(f[1]) + 18'(f[3]) + 18'(f[5]) + 18'(f[7]);
        k = 18'(f[0]) + 18'(f[2]) + 18'(f[6]) + 18'(f[8]);
        return $signed(23'({e, 2'b00})) + $signed(23'(k)) - $signed(23'(f[4]) * 23'd20);
    endfunction

    function automatic logic [22:0] bias_q(input logic signed [63:0] q);
        logic signed [63:0] c;
        c = q;
        if (c > 64'(Q_LIM - 1)) begin
            c = 64'(Q_LIM - 1);
        end else if (c < -64'(Q_LIM)) begin
            c = -64'(Q_LIM);
        end
        return 23'(c + 64'(Q_BIAS));
    endfunction

    function automatic logic [15:0] sat_q(input logic [15:0] c, input logic [45:0] m);
        logic signed [23:0] s;
        s = $signed(24'(c)) + $signed(24'(m[45:RECIP_SHIFT])) - $signed(24'(Q_LIM));
        if (s < 0) begin
            return 16'd0;
        end else if (s > $signed(24'(ONE_Q15))) begin
            return ONE_Q15;
        end
        return s[15:0];
    endfunction

    logic [8:0][15:0] f_a, f_b;
    logic [15:0] c_a, c_b;
    logic [5:0]  r_vld;

    logic [31:0] r1_ab, r1_ka;
    logic [32:0] r1_kb;
    logic signed [22:0] r1_la, r1_lb;
    logic [15:0] r1_ca, r1_cb;

    logic [47:0] r2_abb;
    logic signed [39:0] r2_pa, r2_pb;
    logic [31:0] r2_ka;
    logic [32:0] r2_kb;
    logic [15:0] r2_ca, r2_cb;

    logic signed [63:0] x_a, x_b;
    logic [22:0] r3_ua, r3_ub;
    logic [15:0] r3_ca, r3_cb;

    logic [45:0] r4_ma, r4_mb;
    logic [15:0] r4_ca, r4_cb;

    logic [15:0] r5_na, r5_nb;
    logic [15:0] r6_na, r6_nb;
    logic [7:0]  r6_grey;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            f_a[i] = i_taps[i][31:16];
            f_b[i] = i_taps[i][15:0];
        end
    end
    assign c_a = i_taps[4][31:16];
    assign c_b = i_taps[4][15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[4:0], i_start};
        end
    end

    always_comb begin
        x_a = ((64'(r2_pa) + 64'($signed({1'b0, r2_ka})) * 64'sd20) <<< 15)
            - 64'($signed({1'b0, r2_abb})) * 64'sd20;
        x_b = ((64'(r2_pb) - 64'($signed({1'b0, r2_kb})) * 64'sd20) <<< 15)
            + 64'($signed({1'b0, r2_abb})) * 64'sd20;
    end

    always_ff @(posedge i_clk) begin
        r1_ab <= 32'(c_a) * 32'(c_b);
        r1_ka <= 32'(i_rates.feed) * 32'(17'(ONE_Q15) - 17'(c_a));
        r1_kb <= 33'(17'(i_rates.kill) + 17'(i_rates.feed)) * 33'(c_b);
        r1_la <= lap20(f_a);
        r1_lb <= lap20(f_b);
        r1_ca <= c_a;
        r1_cb <= c_b;

        r2_abb <= 48'(r1_ab) * 48'(r1_cb);
        r2_pa  <= 40'($signed({1'b0, i_rates.diff_a})) * 40'(r1_la);
        r2_pb  <= 40'($signed({1'b0, i_rates.diff_b})) * 40'(r1_lb);
        r2_ka  <= r1_ka;
        r2_kb  <= r1_kb;
        r2_ca  <= r1_ca;
        r2_cb  <= r1_cb;

        r3_ua <= bias_q(x_a >>> 32);
        r3_ub <= bias_q(x_b >>> 32);
        r3_ca <= r2_ca;
        r3_cb <= r2_cb;

        r4_ma <= 46'(r3_ua) * 46'(RECIP5);
        r4_mb <= 46'(r3_ub) * 46'(RECIP5);
        r4_ca <= r3_ca;
        r4_cb <= r3_cb;

        r5_na <= sat_q(r4_ca, r4_ma);
        r5_nb <= sat_q(r4_cb, r4_mb);

        r6_na   <= r5_na;
        r6_nb   <= r5_nb;
        r6_grey <= (r5_na > r5_nb) ? 8'(24'(r5_na - r5_nb) * 24'd255 >> 15) : 8'd0;
    end

    assign o_done = r_vld[5];
    assign o_a    = r6_na;
    assign o_b    = r6_nb;
    assign o_grey = r6_grey;
endmodule
